// ===== hdl/tcu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcu_pkg: shared types and constants of the task credential table
// Operation codes, credential entry layout and controller/datapath signals.
// ----------------------------------------------------------------------------
package tcu_pkg;

   localparam int TASK_ENTRIES_DEF = 16;
   localparam int GROUP_SLOTS = 2;
   localparam logic [31:0] ID_KEEP = 32'hFFFF_FFFF;

   localparam int REQ_W = 184;
   localparam int RSP_W = 104;

   localparam logic [3:0] OP_GETUID    = 4'd0;
   localparam logic [3:0] OP_GETGID    = 4'd1;
   localparam logic [3:0] OP_GETEUID   = 4'd2;
   localparam logic [3:0] OP_GETEGID   = 4'd3;
   localparam logic [3:0] OP_REGISTER  = 4'd4;
   localparam logic [3:0] OP_FORK      = 4'd5;
   localparam logic [3:0] OP_EXIT      = 4'd6;
   localparam logic [3:0] OP_GETGROUPS = 4'd7;
   localparam logic [3:0] OP_SETRESUID = 4'd8;
   localparam logic [3:0] OP_SETRESGID = 4'd9;
   localparam logic [3:0] OP_SETGROUPS = 4'd10;
   localparam logic [3:0] OP_HASGROUP  = 4'd11;
   localparam logic [3:0] OP_ACCESS    = 4'd12;

   typedef struct packed {
      logic [31:0] g1;
      logic [31:0] g0;
      logic [1:0]  count;
      logic [31:0] sgid;
      logic [31:0] egid;
      logic [31:0] gid;
      logic [31:0] suid;
      logic [31:0] euid;
      logic [31:0] uid;
   } cred_type;

   typedef struct packed {
      logic latch;
      logic scan_cmp;
      logic scan_next;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_free;
   } status_type;

   function automatic logic in_groups(input cred_type c, input logic [31:0] g);
      logic hit;
      hit = (c.gid == g);
      if (c.count > 2'd0 && c.g0 == g) hit = 1'b1;
      if (c.count > 2'd1 && c.g1 == g) hit = 1'b1;
      return hit;
   endfunction

   function automatic logic [31:0] keep_or_set(input logic [31:0] old,
                                               input logic [31:0] v);
      return (v == ID_KEEP) ? old : v;
   endfunction

endpackage

// ===== hdl/tcu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcu_ram: generic single write, single read ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tcu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcu_ctrl: request sequencer
// Accepts a request, steps the key scan, reads the entry and executes.
// ----------------------------------------------------------------------------
module tcu_ctrl
   import tcu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type stat,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADDR = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_EXE  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: state_in = ST_CMP;
         ST_CMP: begin
            cmd.scan_cmp = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_RD;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_RD: state_in = ST_EXE;
         ST_EXE: begin
            if (stat.rsp_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_exec_free: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> stat.rsp_free) else $error("execute with result pending");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> !req_tready) else $error("request taken while busy");
   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_next |=> state_ff == ST_ADDR) else $error("scan step lost");

endmodule

// ===== hdl/tcu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcu_dp: credential table datapath
// Key scan, entry storage, permission logic and the result register.
// ----------------------------------------------------------------------------
module tcu_dp
   import tcu_pkg::*;
#(
   parameter int TASK_ENTRIES = TASK_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       stat,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int IW = $clog2(TASK_ENTRIES);
   localparam int CW = $bits(cred_type);

   logic [3:0]  op_ff;
   logic [31:0] task_ff, child_ff, id1_ff, id2_ff, id3_ff;
   logic [11:0] mode_ff;
   logic [2:0]  mask_ff;

   logic [TASK_ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0] idx_ff, task_slot_ff, free_slot_ff;
   logic          task_hit_ff, child_hit_ff, free_found_ff;

   logic [31:0] key_rd;
   cred_type    cred_rd;
   logic        key_we, cred_we;
   logic [31:0] key_wd;
   cred_type    cred_wd;
   logic [IW-1:0] wr_slot;

   logic        rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic        ok, found, root;
   logic [31:0] val, g0o, g1o;
   logic [8:0]  need;
   logic        set_v, clr_v;

   tcu_ram #(.WIDTH(32), .DEPTH(TASK_ENTRIES)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(free_slot_ff), .wr_data(key_wd),
      .rd_addr(idx_ff), .rd_data(key_rd)
   );

   tcu_ram #(.WIDTH(CW), .DEPTH(TASK_ENTRIES)) u_cred_ram (
      .clock(clock), .wr_en(cred_we), .wr_addr(wr_slot), .wr_data(cred_wd),
      .rd_addr(task_slot_ff), .rd_data(cred_rd)
   );

   assign stat.scan_last = (idx_ff == IW'(TASK_ENTRIES - 1));
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      ok = 1'b0;
      val = '0;
      g0o = '0;
      g1o = '0;
      need = '0;
      key_wd = task_ff;
      cred_wd = cred_rd;
      wr_slot = task_slot_ff;
      cred_we = 1'b0;
      key_we = 1'b0;
      set_v = 1'b0;
      clr_v = 1'b0;
      found = task_hit_ff && (task_ff != 32'd0);
      root = (cred_rd.euid == 32'd0);
      case (op_ff) inside
         OP_GETUID, OP_GETGID, OP_GETEUID, OP_GETEGID: begin
            ok = found;
            case (op_ff)
               OP_GETUID:  val = cred_rd.uid;
               OP_GETGID:  val = cred_rd.gid;
               OP_GETEUID: val = cred_rd.euid;
               default:    val = cred_rd.egid;
            endcase
         end
         OP_REGISTER: begin
            ok = (task_ff != 32'd0) && !found && free_found_ff;
            cred_wd = '0;
            cred_wd.count = 2'd2;
            cred_wd.g1 = 32'd1;
            wr_slot = free_slot_ff;
            key_we = ok;
            cred_we = ok;
            set_v = ok;
         end
         OP_FORK: begin
            ok = (task_ff != 32'd0) && (child_ff != 32'd0) && !child_hit_ff
                 && found && free_found_ff;
            key_wd = child_ff;
            wr_slot = free_slot_ff;
            key_we = ok;
            cred_we = ok;
            set_v = ok;
         end
         OP_EXIT: begin
            ok = 1'b1;
            clr_v = found;
         end
         OP_GETGROUPS: begin
            ok = found && !((id1_ff != 32'd0) && (id1_ff < {30'd0, cred_rd.count}))
                 && (cred_rd.count <= 2'd2);
            val = {30'd0, cred_rd.count};
            g0o = (cred_rd.count > 2'd0) ? cred_rd.g0 : 32'd0;
            g1o = (cred_rd.count > 2'd1) ? cred_rd.g1 : 32'd0;
         end
         OP_SETRESUID: begin
            ok = found && root;
            cred_wd.uid  = keep_or_set(cred_rd.uid, id1_ff);
            cred_wd.euid = keep_or_set(cred_rd.euid, id2_ff);
            cred_wd.suid = keep_or_set(cred_rd.suid, id3_ff);
            cred_we = ok;
         end
         OP_SETRESGID: begin
            ok = found && root;
            cred_wd.gid  = keep_or_set(cred_rd.gid, id1_ff);
            cred_wd.egid = keep_or_set(cred_rd.egid, id2_ff);
            cred_wd.sgid = keep_or_set(cred_rd.sgid, id3_ff);
            cred_we = ok;
         end
         OP_SETGROUPS: begin
            ok = found && root && (id1_ff <= 32'(GROUP_SLOTS));
            cred_wd.count = id1_ff[1:0];
            cred_wd.g0 = (id1_ff > 32'd0) ? id2_ff : 32'd0;
            cred_wd.g1 = (id1_ff > 32'd1) ? id3_ff : 32'd0;
            cred_we = ok;
         end
         OP_HASGROUP: begin
            ok = found;
            val = {31'd0, in_groups(cred_rd, id1_ff)};
         end
         OP_ACCESS: begin
            ok = found;
            if (cred_rd.euid == id1_ff) begin
               need = {mask_ff, 6'd0};
            end else if (cred_rd.egid == id2_ff || in_groups(cred_rd, id2_ff)) begin
               need = {3'd0, mask_ff, 3'd0};
            end else begin
               need = {6'd0, mask_ff};
            end
            val = {31'd0, root || ((mode_ff[8:0] & need) == need)};
         end
         default: ok = 1'b0;
      endcase
      if (!ok) begin
         val = '0;
         g0o = '0;
         g1o = '0;
      end
      key_we = key_we && cmd.exec;
      cred_we = cred_we && cmd.exec;
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.exec && set_v) valid_in[free_slot_ff] = 1'b1;
      if (cmd.exec && clr_v) valid_in[task_slot_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_tdata[3:0];
         task_ff  <= req_tdata[35:4];
         child_ff <= req_tdata[67:36];
         id1_ff   <= req_tdata[99:68];
         id2_ff   <= req_tdata[131:100];
         id3_ff   <= req_tdata[163:132];
         mode_ff  <= req_tdata[175:164];
         mask_ff  <= req_tdata[178:176];
      end
      if (cmd.exec) begin
         rsp_data_ff <= {7'd0, g1o, g0o, val, !ok};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         idx_ff        <= '0;
         task_slot_ff  <= '0;
         free_slot_ff  <= '0;
         task_hit_ff   <= 1'b0;
         child_hit_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.latch) begin
            idx_ff        <= '0;
            task_hit_ff   <= 1'b0;
            child_hit_ff  <= 1'b0;
            free_found_ff <= 1'b0;
         end
         if (cmd.scan_cmp) begin
            if (valid_ff[idx_ff] && key_rd == task_ff) begin
               task_hit_ff  <= 1'b1;
               task_slot_ff <= idx_ff;
            end
            if (valid_ff[idx_ff] && key_rd == child_ff) begin
               child_hit_ff <= 1'b1;
            end
            if (!valid_ff[idx_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_slot_ff  <= idx_ff;
            end
         end
         if (cmd.scan_next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_key_free: assert property (@(posedge clock) disable iff (reset)
      key_we |-> free_found_ff) else $error("entry created without free slot");
   a_key_valid: assert property (@(posedge clock) disable iff (reset)
      key_we |=> valid_ff[$past(free_slot_ff)]) else $error("new entry not valid");
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      cred_we |-> (task_hit_ff || free_found_ff)) else $error("write without slot");

endmodule

// ===== hdl/task_credential_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_credential_table_unit: per-task credential table
// Requests on req_* look up, create, copy, change or remove credential entries
// keyed by task number and return one response on rsp_*.
// One request is in flight at a time. After acceptance the key store is
// scanned entry by entry (a ram read state, then a compare state), then the
// credential entry is read and the request executed: the response appears
// in the output register and req_tready returns high in that same cycle.
// The key ram scan takes most of the time of a request.
// The response sits in an output register; if rsp_tready is low the next
// request is still accepted and scanned, and it waits before execution until
// the previous response has been taken.
// Reset clears all entry valid bits and any pending response; the table is
// usable in the next cycle.
// ----------------------------------------------------------------------------
module task_credential_table_unit
   import tcu_pkg::*;
#(
   parameter int TASK_ENTRIES = TASK_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // operation, task_req, second_task, first_id, second_id, third_id,
   // mode_bits, access_mask
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status, result_value, first_group, second_group
   output logic [RSP_W-1:0] rsp_tdata
);

   cmd_type    cmd;
   status_type stat;

   tcu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .stat(stat), .cmd(cmd)
   );

   tcu_dp #(.TASK_ENTRIES(TASK_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

endmodule
